### design/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg: shared types and constants of the HEX record line parser
// Record phases, result codes, the result beat layout and the digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hrp_pkg;

    // Parser phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    // Result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    // Record status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LEN_ODD  = 2'd1;
    localparam logic [1:0] ST_NO_START = 2'd2;

    localparam logic [7:0] START_CHAR = 8'h3A;  // ':'

    typedef struct packed {
        logic        kind;
        logic [15:0] word_value;
        logic [6:0]  word_index;
        logic [7:0]  byte_count;
        logic [15:0] load_address;
        logic [7:0]  record_type;
        logic [7:0]  check_byte;
        logic [1:0]  status;
    } result_t;

    // Upper-case hex digit to its value; anything else reads as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            d = c - 8'h30;
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

### design/hrp_if.sv
// ----------------------------------------------------------------------------
// hrp_if: channel interfaces of the HEX record line parser
// A character channel and a result channel, both valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       line_begin;

    modport source (output valid, output text_char, output line_begin, input ready);
    modport sink   (input valid, input text_char, input line_begin, output ready);
endinterface

interface hrp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] word_value;
    logic [6:0]  word_index;
    logic [7:0]  byte_count;
    logic [15:0] load_address;
    logic [7:0]  record_type;
    logic [7:0]  check_byte;
    logic [1:0]  status;

    modport source (output valid, output kind, output word_value, output word_index,
                    output byte_count, output load_address, output record_type,
                    output check_byte, output status, input ready);
    modport sink   (input valid, input kind, input word_value, input word_index,
                    input byte_count, input load_address, input record_type,
                    input check_byte, input status, output ready);
endinterface

`default_nettype wire

### design/hrp_parser.sv
// ----------------------------------------------------------------------------
// hrp_parser: per-character record parser
// Holds the field state and decodes one character per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hrp_parser
    import hrp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] text_char,
    input  wire logic       line_begin,
    output result_t         result,
    output logic            result_valid
);

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  digit_pos_reg, digit_pos_next;
    logic [15:0] nibble_acc_reg, nibble_acc_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [6:0]  words_done_reg, words_done_next;

    logic [15:0] acc_shift;
    logic [1:0]  pos;
    logic [6:0]  words_total;
    logic [6:0]  words_inc;

    assign acc_shift   = {nibble_acc_reg[11:0], hex_value(text_char)};
    assign pos         = digit_pos_reg + 2'd1;
    assign words_total = count_reg[7:1];
    assign words_inc   = words_done_reg + 7'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        digit_pos_next  = digit_pos_reg;
        nibble_acc_next = nibble_acc_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        type_next       = type_reg;
        words_done_next = words_done_reg;
        result_valid    = 1'b0;
        result          = '0;

        if (accept)
        begin
            if (line_begin)
            begin
                // A line start always drops whatever record was in progress.
                count_next      = 8'd0;
                addr_next       = 16'd0;
                type_next       = 8'd0;
                words_done_next = 7'd0;
                digit_pos_next  = 2'd0;
                nibble_acc_next = 16'd0;
                if (text_char == START_CHAR)
                begin
                    phase_next = PH_COUNT;
                end
                else
                begin
                    phase_next    = PH_IDLE;
                    result_valid  = 1'b1;
                    result.kind   = KIND_RECORD;
                    result.status = ST_NO_START;
                end
            end
            else if (phase_reg >= PH_COUNT && phase_reg <= PH_CHECK)
            begin
                nibble_acc_next = acc_shift;
                digit_pos_next  = pos;
                case (phase_reg)
                    PH_COUNT:
                    begin
                        if (pos == 2'd2)
                        begin
                            count_next      = acc_shift[7:0];
                            phase_next      = PH_ADDR;
                            digit_pos_next  = 2'd0;
                            nibble_acc_next = 16'd0;
                        end
                    end
                    PH_ADDR:
                    begin
                        if (pos == 2'd0)
                        begin
                            addr_next       = acc_shift;
                            phase_next      = PH_TYPE;
                            digit_pos_next  = 2'd0;
                            nibble_acc_next = 16'd0;
                        end
                    end
                    PH_TYPE:
                    begin
                        if (pos == 2'd2)
                        begin
                            type_next       = acc_shift[7:0];
                            phase_next      = (words_total == 7'd0) ? PH_CHECK : PH_DATA;
                            digit_pos_next  = 2'd0;
                            nibble_acc_next = 16'd0;
                        end
                    end
                    PH_DATA:
                    begin
                        if (pos == 2'd0)
                        begin
                            result_valid        = 1'b1;
                            result.kind         = KIND_WORD;
                            result.word_value   = acc_shift;
                            result.word_index   = words_done_reg;
                            result.byte_count   = count_reg;
                            result.load_address = addr_reg;
                            result.record_type  = type_reg;
                            words_done_next     = words_inc;
                            phase_next      = (words_inc >= words_total) ? PH_CHECK : PH_DATA;
                            digit_pos_next  = 2'd0;
                            nibble_acc_next = 16'd0;
                        end
                    end
                    default:
                    begin
                        // Checksum field: report the record after its second digit.
                        if (pos == 2'd2)
                        begin
                            result_valid        = 1'b1;
                            result.kind         = KIND_RECORD;
                            result.byte_count   = count_reg;
                            result.load_address = addr_reg;
                            result.record_type  = type_reg;
                            result.check_byte   = acc_shift[7:0];
                            result.status       = count_reg[0] ? ST_LEN_ODD : ST_OK;
                            phase_next      = PH_DONE;
                            digit_pos_next  = 2'd0;
                            nibble_acc_next = 16'd0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            digit_pos_reg  <= 2'd0;
            nibble_acc_reg <= 16'd0;
            count_reg      <= 8'd0;
            addr_reg       <= 16'd0;
            type_reg       <= 8'd0;
            words_done_reg <= 7'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            digit_pos_reg  <= digit_pos_next;
            nibble_acc_reg <= nibble_acc_next;
            count_reg      <= count_next;
            addr_reg       <= addr_next;
            type_reg       <= type_next;
            words_done_reg <= words_done_next;
        end
    end

endmodule

`default_nettype wire

### design/hrp_out_stage.sv
// ----------------------------------------------------------------------------
// hrp_out_stage: result register with skid entry
// Keeps the character side moving while a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hrp_out_stage
    import hrp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         can_accept,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop        = out_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // No beat is taken while the skid entry is full.
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

### design/hex_record_line_parser.sv
// ----------------------------------------------------------------------------
// hex_record_line_parser: HEX record line parser, top level
// Decodes record lines one character per beat into data words and records.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the result skid entry is empty.
// A result is registered in the result register, or in its skid entry while
// an earlier result waits, before it shows on the result channel.
// Reset: rst_n clears the parser to idle and empties the result register
// and its skid entry; no result is pending after reset.
`default_nettype none

module hex_record_line_parser
    import hrp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    hrp_char_if.sink      chars,
    hrp_result_if.source  records
);

    logic    accept;
    logic    can_accept;
    logic    push;
    result_t push_data;
    result_t out_data;

    assign chars.ready = can_accept;
    assign accept      = chars.valid && can_accept;

    hrp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .text_char    (chars.text_char),
        .line_begin   (chars.line_begin),
        .result       (push_data),
        .result_valid (push)
    );

    hrp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .can_accept (can_accept),
        .out_valid  (records.valid),
        .out_ready  (records.ready),
        .out_data   (out_data)
    );

    assign records.kind         = out_data.kind;
    assign records.word_value   = out_data.word_value;
    assign records.word_index   = out_data.word_index;
    assign records.byte_count   = out_data.byte_count;
    assign records.load_address = out_data.load_address;
    assign records.record_type  = out_data.record_type;
    assign records.check_byte   = out_data.check_byte;
    assign records.status       = out_data.status;

endmodule

`default_nettype wire

### design/hrp_checker.sv
// ----------------------------------------------------------------------------
// hrp_checker: port-level checks of the HEX record line parser
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hrp_checker
    import hrp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  text_char,
    input wire logic        line_begin,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        kind,
    input wire logic [15:0] word_value,
    input wire logic [6:0]  word_index,
    input wire logic [7:0]  byte_count,
    input wire logic [15:0] load_address,
    input wire logic [7:0]  record_type,
    input wire logic [7:0]  check_byte,
    input wire logic [1:0]  status
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_value) && $stable(status)
            && $stable(kind) && $stable(check_byte))
        else $error("result beat changed while stalled");

    // Character side only stalls when a result is already waiting.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("character channel stalled with no result pending");

    // A line start without a colon always produces a result.
    a_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && line_begin && text_char != START_CHAR |=> out_valid)
        else $error("missing start colon produced no result");

    // Data word beats carry no record status or checksum.
    a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_WORD |-> status == ST_OK && check_byte == 8'd0)
        else $error("data word beat carries record fields");

    // A rejected line reports empty header fields.
    a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_RECORD && status == ST_NO_START
            |-> byte_count == 8'd0 && load_address == 16'd0 && record_type == 8'd0
                && word_index == 7'd0)
        else $error("rejected line carries header fields");

endmodule

bind hex_record_line_parser hrp_checker u_hrp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (chars.valid),
    .in_ready     (chars.ready),
    .text_char    (chars.text_char),
    .line_begin   (chars.line_begin),
    .out_valid    (records.valid),
    .out_ready    (records.ready),
    .kind         (records.kind),
    .word_value   (records.word_value),
    .word_index   (records.word_index),
    .byte_count   (records.byte_count),
    .load_address (records.load_address),
    .record_type  (records.record_type),
    .check_byte   (records.check_byte),
    .status       (records.status)
);

`default_nettype wire
